/* rtl/utf8_to_utf16_stream_macros.svh */
// Assertion macros used by the checker module.
`ifndef UTF8_TO_UTF16_STREAM_MACROS_SVH
`define UTF8_TO_UTF16_STREAM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define U2U_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define U2U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/u2u_pkg.sv */
package u2u_pkg;

    // Lead byte masks and patterns.
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;

    // Surrogate construction constants.
    localparam logic [20:0] SUPP_BASE      = 21'h10000;
    localparam logic [15:0] SURR_HIGH_BASE = 16'hD800;
    localparam logic [15:0] SURR_LOW_BASE  = 16'hDC00;

    // Classification of a byte seen where a lead is expected.
    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_STRAY
    } u2u_lead_t;

    // Units produced by one code point.
    typedef struct packed {
        logic        two;
        logic [15:0] first;
        logic [15:0] second;
    } u2u_units_t;

    // Results caused by one byte, handed from the decoder to the output register.
    typedef struct packed {
        logic [15:0] unit_first;
        logic [15:0] unit_second;
        logic        has_second;
        logic        unit_valid;
        logic        string_end;
    } u2u_result_t;

    function automatic u2u_lead_t u2u_lead_class(input logic [7:0] b);
        u2u_lead_t cls;
        if ((b & ASCII_MASK) == 8'h00) begin
            cls = LEAD_ASCII;
        end
        else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            cls = LEAD_TWO;
        end
        else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            cls = LEAD_THREE;
        end
        else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            cls = LEAD_FOUR;
        end
        else begin
            cls = LEAD_STRAY;
        end
        return cls;
    endfunction

    // Builds a code point from a lead and n followers, in order f0, f1, f2.
    function automatic logic [20:0] u2u_compose(input logic [7:0] lead, input logic [1:0] n,
                                                input logic [7:0] f0, input logic [7:0] f1,
                                                input logic [7:0] f2);
        logic [20:0] cp;
        unique case (n)
            2'd1:    cp = {10'd0, lead[4:0], f0[5:0]};
            2'd2:    cp = {5'd0, lead[3:0], f0[5:0], f1[5:0]};
            2'd3:    cp = {lead[2:0], f0[5:0], f1[5:0], f2[5:0]};
            default: cp = {14'd0, lead[6:0]};
        endcase
        return cp;
    endfunction

    // Turns a code point into one unit or a surrogate pair.
    function automatic u2u_units_t u2u_push(input logic [20:0] cp);
        u2u_units_t  u;
        logic [20:0] v;
        v = cp - SUPP_BASE;
        if (cp[20:16] == 5'd0) begin
            u.two    = 1'b0;
            u.first  = cp[15:0];
            u.second = 16'd0;
        end
        else begin
            u.two    = 1'b1;
            u.first  = SURR_HIGH_BASE + {5'd0, v[20:10]};
            u.second = SURR_LOW_BASE + {6'd0, v[9:0]};
        end
        return u;
    endfunction

endpackage

/* rtl/u2u_decode.sv */
module u2u_decode
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        emit,
    output u2u_result_t result
);

    logic [7:0]  lead_reg;
    logic [7:0]  lead_next;
    logic [1:0]  need_reg;
    logic [1:0]  need_next;
    logic [1:0]  have_reg;
    logic [1:0]  have_next;
    logic [7:0]  store_reg [2];
    logic        store_we;
    u2u_lead_t   cls;
    u2u_lead_t   cls_first;
    logic [20:0] cp;
    logic [20:0] cp_pair;
    u2u_units_t  units;
    logic [1:0]  cnt;
    logic [15:0] unit_a;
    logic [15:0] unit_b;
    logic        complete;

    assign cls       = u2u_lead_class(data_byte);
    assign cls_first = u2u_lead_class(store_reg[0]);
    assign complete  = ({1'b0, have_reg} + 3'd1) >= {1'b0, need_reg};

    // Code point of the sequence that this byte completes.
    always_comb
    begin
        unique case (need_reg)
            2'd1:    cp = u2u_compose(lead_reg, 2'd1, data_byte, 8'd0, 8'd0);
            2'd2:    cp = u2u_compose(lead_reg, 2'd2, store_reg[0], data_byte, 8'd0);
            default: cp = u2u_compose(lead_reg, 2'd3, store_reg[0], store_reg[1], data_byte);
        endcase
    end

    // Two-byte character formed by the held follower and this byte.
    assign cp_pair = u2u_compose(store_reg[0], 2'd1, data_byte, 8'd0, 8'd0);

    assign units = u2u_push(cp);

    // Decode of the current byte and next state of the open sequence.
    always_comb
    begin
        lead_next = lead_reg;
        need_next = need_reg;
        have_next = have_reg;
        store_we  = 1'b0;
        cnt       = 2'd0;
        unit_a    = 16'd0;
        unit_b    = 16'd0;

        priority if (need_reg == 2'd0)
        begin
            unique case (cls)
                LEAD_ASCII:
                begin
                    cnt    = 2'd1;
                    unit_a = {8'd0, data_byte};
                end
                LEAD_TWO, LEAD_THREE, LEAD_FOUR:
                begin
                    if (!final_byte)
                    begin
                        lead_next = data_byte;
                        have_next = 2'd0;
                        unique case (cls)
                            LEAD_TWO:   need_next = 2'd1;
                            LEAD_THREE: need_next = 2'd2;
                            default:    need_next = 2'd3;
                        endcase
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (complete)
        begin
            cnt       = units.two ? 2'd2 : 2'd1;
            unit_a    = units.first;
            unit_b    = units.second;
            lead_next = 8'd0;
            need_next = 2'd0;
            have_next = 2'd0;
        end
        else if (final_byte)
        begin
            // Truncated sequence: the held followers and this byte act as fresh leads.
            if (have_reg == 2'd0)
            begin
                if (cls == LEAD_ASCII)
                begin
                    cnt    = 2'd1;
                    unit_a = {8'd0, data_byte};
                end
            end
            else
            begin
                unique case (cls_first)
                    LEAD_ASCII:
                    begin
                        unit_a = {8'd0, store_reg[0]};
                        if (cls == LEAD_ASCII)
                        begin
                            cnt    = 2'd2;
                            unit_b = {8'd0, data_byte};
                        end
                        else
                        begin
                            cnt = 2'd1;
                        end
                    end
                    LEAD_TWO:
                    begin
                        cnt    = 2'd1;
                        unit_a = cp_pair[15:0];
                    end
                    default:
                    begin
                        if (cls == LEAD_ASCII)
                        begin
                            cnt    = 2'd1;
                            unit_a = {8'd0, data_byte};
                        end
                    end
                endcase
            end
        end
        else
        begin
            store_we  = 1'b1;
            have_next = have_reg + 2'd1;
        end

        // The end of a string always returns to idle.
        if (final_byte)
        begin
            lead_next = 8'd0;
            need_next = 2'd0;
            have_next = 2'd0;
        end
    end

    // Result packet; a final byte without a unit gives a bare end marker.
    always_comb
    begin
        emit              = (cnt != 2'd0) || final_byte;
        result.unit_first  = unit_a;
        result.unit_second = unit_b;
        result.has_second  = (cnt == 2'd2);
        result.unit_valid  = (cnt != 2'd0);
        result.string_end  = final_byte;
    end

    // Sequence state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lead_reg <= 8'd0;
            need_reg <= 2'd0;
            have_reg <= 2'd0;
        end
        else if (take)
        begin
            lead_reg <= lead_next;
            need_reg <= need_next;
            have_reg <= have_next;
        end
    end

    // Follower bytes of the open sequence.
    always_ff @(posedge clk)
    begin
        if (take && store_we)
        begin
            store_reg[have_reg[0]] <= data_byte;
        end
    end

endmodule

/* rtl/u2u_out.sv */
module u2u_out
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  u2u_result_t result,
    input  logic        result_stall,
    output logic        free,
    output logic        result_valid,
    output logic [15:0] code_unit,
    output logic        unit_valid,
    output logic        run_last,
    output logic        string_end
);

    logic        valid_reg;
    logic        valid_next;
    logic        sel_reg;
    logic        sel_next;
    u2u_result_t pkt_reg;
    logic        last;

    // The second unit of a pair is shown once the first has been taken.
    assign last = !pkt_reg.has_second || sel_reg;
    assign free = !valid_reg || (!result_stall && last);

    assign result_valid = valid_reg;
    assign code_unit    = sel_reg ? pkt_reg.unit_second : pkt_reg.unit_first;
    assign unit_valid   = pkt_reg.unit_valid;
    assign run_last     = last;
    assign string_end   = last && pkt_reg.string_end;

    // Next state of the result register.
    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        priority if (load)
        begin
            valid_next = 1'b1;
            sel_next   = 1'b0;
        end
        else if (valid_reg && !result_stall)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                sel_next = 1'b1;
            end
        end
        else
        begin
            // Empty or stalled: the register holds.
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_reg <= result;
        end
    end

endmodule

/* rtl/utf8_to_utf16_stream.sv */
// Lenient UTF-8 to UTF-16 decoder, one byte per request.
// A byte is held in the input register, decoded combinationally and then registered in the result register.
// Throughput: one byte per cycle while results are not stalled; a byte that yields a surrogate pair or two
// units holds the input while the second unit is delivered.
// Reset (rst_n, asynchronous, active low) empties both registers and closes any open sequence.
module utf8_to_utf16_stream
    import u2u_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] code_unit,
    output logic        unit_valid,
    output logic        run_last,
    output logic        string_end
);

    logic        in_valid_reg;
    logic [7:0]  byte_reg;
    logic        final_reg;
    logic        emit;
    logic        free;
    logic        adv;
    u2u_result_t result;

    // The held byte moves on when it has no result or the result register frees up.
    assign adv        = in_valid_reg && (!emit || free);
    assign byte_stall = in_valid_reg && !adv;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_valid && !byte_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            byte_reg  <= data_byte;
            final_reg <= final_byte;
        end
    end

    u2u_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (adv),
        .data_byte  (byte_reg),
        .final_byte (final_reg),
        .emit       (emit),
        .result     (result)
    );

    u2u_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (adv && emit),
        .result       (result),
        .result_stall (result_stall),
        .free         (free),
        .result_valid (result_valid),
        .code_unit    (code_unit),
        .unit_valid   (unit_valid),
        .run_last     (run_last),
        .string_end   (string_end)
    );

endmodule

/* rtl/u2u_checker.sv */
`include "utf8_to_utf16_stream_macros.svh"

module u2u_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        byte_valid,
    input logic        byte_stall,
    input logic [7:0]  data_byte,
    input logic        final_byte,
    input logic        result_valid,
    input logic        result_stall,
    input logic [15:0] code_unit,
    input logic        unit_valid,
    input logic        run_last,
    input logic        string_end
);

    // A stalled result keeps its value.
    `U2U_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(code_unit) && $stable(run_last) && $stable(string_end), "stalled result changed")

    // A bare end marker closes both the byte's run and the string.
    `U2U_ASSERT_NOW(a_marker_shape, clk, rst_n, result_valid && !unit_valid, run_last && string_end && code_unit == 16'd0, "malformed end marker")

    // The end of a string is always the last result of its byte.
    `U2U_ASSERT_NOW(a_end_is_last, clk, rst_n, result_valid && string_end, run_last, "string end before run end")

    // The second result of a byte follows right after the first is taken.
    `U2U_ASSERT_NEXT(a_second_follows, clk, rst_n, result_valid && !result_stall && !run_last, result_valid && unit_valid, "second result missing")

endmodule

bind utf8_to_utf16_stream u2u_checker u_checker (.*);

/* sim/utf8_to_utf16_stream_tb.sv */
`timescale 1ns / 100ps

module utf8_to_utf16_stream_tb;
    import u2u_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int BYTES_PER_PHASE = 230;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } byte_req_t;

    typedef struct packed {
        logic [15:0] code;
        logic        valid;
        logic        last;
        logic        str_end;
    } unit_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        byte_valid = 1'b0;
    logic        byte_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        final_byte = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        run_last;
    logic        string_end;

    byte_req_t   bytes_to_send[$];
    unit_rec_t   units_due[$];
    logic [15:0] fresh_units[$];
    byte_req_t   next_req;
    unit_rec_t   due;
    int          send_idle_pct = 28;
    int          recv_stall_pct = 65;
    int          queued_total = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;

    // Decoder state kept by the predictor.
    logic [7:0]  held_lead = 8'h00;
    logic [1:0]  need_cnt = 2'd0;
    logic [1:0]  have_cnt = 2'd0;
    logic [7:0]  held_followers [2];

    utf8_to_utf16_stream i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .final_byte   (final_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .code_unit    (code_unit),
        .unit_valid   (unit_valid),
        .run_last     (run_last),
        .string_end   (string_end)
    );

    always #5 clk = ~clk;

    // Sorts a byte seen where a lead is expected.
    function automatic u2u_lead_t classify(input logic [7:0] b);
        casez (b)
            8'b0???????: return LEAD_ASCII;
            8'b110?????: return LEAD_TWO;
            8'b1110????: return LEAD_THREE;
            8'b11110???: return LEAD_FOUR;
            default:     return LEAD_STRAY;
        endcase
    endfunction

    function automatic int followers_for(input u2u_lead_t cls);
        case (cls)
            LEAD_TWO:   return 1;
            LEAD_THREE: return 2;
            LEAD_FOUR:  return 3;
            default:    return 0;
        endcase
    endfunction

    // Payload bits that a lead contributes, given how many followers it takes.
    function automatic logic [20:0] lead_payload(input logic [7:0] lead, input int n);
        case (n)
            1:       return {16'd0, lead[4:0]};
            2:       return {17'd0, lead[3:0]};
            3:       return {18'd0, lead[2:0]};
            default: return {14'd0, lead[6:0]};
        endcase
    endfunction

    // Appends one code point as a single unit or as a surrogate pair.
    task automatic emit_code_point(input logic [20:0] cp);
        logic [20:0] offset;
        offset = cp - SUPP_BASE;
        if (cp > 21'h00FFFF)
        begin
            fresh_units.insert(fresh_units.size(), SURR_HIGH_BASE + {5'd0, offset[20:10]});
            fresh_units.insert(fresh_units.size(), SURR_LOW_BASE + {6'd0, offset[9:0]});
        end
        else
        begin
            fresh_units.insert(fresh_units.size(), cp[15:0]);
        end
    endtask

    // Advances the predicted decoder by one accepted byte and queues its units.
    task automatic decode_byte(input logic [7:0] b, input logic fin);
        logic [7:0]  run[$];
        logic [20:0] cp;
        u2u_lead_t   cls;
        unit_rec_t   rec;
        int          n;
        int          i;
        int          j;
        fresh_units.delete();
        if (need_cnt == 2'd0)
        begin
            cls = classify(b);
            if (cls == LEAD_ASCII)
            begin
                emit_code_point(lead_payload(b, 0));
            end
            else if (cls != LEAD_STRAY && !fin)
            begin
                held_lead = b;
                need_cnt = 2'(followers_for(cls));
                have_cnt = 2'd0;
            end
        end
        else if (int'(have_cnt) + 1 >= int'(need_cnt))
        begin
            // The sequence is complete with this byte.
            cp = lead_payload(held_lead, int'(need_cnt));
            for (j = 0; j < int'(have_cnt); j++)
                cp = {cp[14:0], held_followers[j][5:0]};
            cp = {cp[14:0], b[5:0]};
            emit_code_point(cp);
            need_cnt = 2'd0;
            have_cnt = 2'd0;
        end
        else if (fin)
        begin
            // Truncated at the end: drop the lead and read the rest as fresh leads.
            for (j = 0; j < int'(have_cnt); j++)
                run.insert(run.size(), held_followers[j]);
            run.insert(run.size(), b);
            i = 0;
            while (i < run.size())
            begin
                cls = classify(run[i]);
                n = followers_for(cls);
                i++;
                if (cls != LEAD_STRAY && n <= run.size() - i)
                begin
                    cp = lead_payload(run[i - 1], n);
                    for (j = 0; j < n; j++)
                        cp = {cp[14:0], run[i + j][5:0]};
                    emit_code_point(cp);
                    i += n;
                end
            end
        end
        else
        begin
            held_followers[have_cnt[0]] = b;
            have_cnt = have_cnt + 2'd1;
        end

        while (fresh_units.size() > 2)
            void'(fresh_units.pop_back());

        if (fin)
        begin
            held_lead = 8'h00;
            need_cnt = 2'd0;
            have_cnt = 2'd0;
        end

        // A final byte that yields nothing still closes the string.
        if (fin && fresh_units.size() == 0)
        begin
            rec = '{code: 16'd0, valid: 1'b0, last: 1'b1, str_end: 1'b1};
            units_due.insert(units_due.size(), rec);
        end
        for (j = 0; j < fresh_units.size(); j++)
        begin
            rec.code = fresh_units[j];
            rec.valid = 1'b1;
            rec.last = (j == fresh_units.size() - 1);
            rec.str_end = rec.last && fin;
            units_due.insert(units_due.size(), rec);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic fin);
        byte_req_t req;
        req.data = b;
        req.fin = fin;
        bytes_to_send.insert(bytes_to_send.size(), req);
        queued_total++;
    endtask

    function automatic logic [7:0] random_lead(input int n);
        case (n)
            1:       return {3'b110, 5'($urandom)};
            2:       return {4'b1110, 4'($urandom)};
            default: return {5'b11110, 3'($urandom)};
        endcase
    endfunction

    // Mostly a proper continuation byte, sometimes any byte at all.
    function automatic logic [7:0] random_follower();
        if ($urandom_range(9) != 0)
            return {2'b10, 6'($urandom)};
        return 8'($urandom);
    endfunction

    // One string of mostly well-formed characters, with some stray and cut-off sequences.
    task automatic random_string();
        logic [7:0] seq[$];
        logic [7:0] pick;
        int         parts;
        int         kind;
        int         n;
        int         p;
        int         j;
        parts = $urandom_range(1, 6);
        for (p = 0; p < parts; p++)
        begin
            kind = (p == parts - 1 && $urandom_range(99) < 15) ? 97 : $urandom_range(99);
            if (kind < 40)
            begin
                pick = {1'b0, 7'($urandom)};
                seq.insert(seq.size(), pick);
            end
            else if (kind < 90)
            begin
                n = (kind < 60) ? 1 : (kind < 75) ? 2 : 3;
                seq.insert(seq.size(), random_lead(n));
                for (j = 0; j < n; j++)
                    seq.insert(seq.size(), random_follower());
            end
            else if (kind < 95)
            begin
                pick = $urandom_range(1) ? {2'b10, 6'($urandom)}
                                         : {5'b11111, 3'($urandom)};
                seq.insert(seq.size(), pick);
            end
            else
            begin
                n = $urandom_range(1, 3);
                seq.insert(seq.size(), random_lead(n));
                for (j = $urandom_range(0, n - 1); j > 0; j--)
                    seq.insert(seq.size(), random_follower());
            end
        end
        for (j = 0; j < seq.size(); j++)
            push_byte(seq[j], j == seq.size() - 1);
    endtask

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    // Request driver: predicts each accepted byte, then offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            data_byte <= 8'h00;
            final_byte <= 1'b0;
        end
        else
        begin
            if (byte_valid && !byte_stall)
                decode_byte(data_byte, final_byte);
            if (!byte_valid || !byte_stall)
            begin
                if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_req = bytes_to_send.pop_front();
                    byte_valid <= 1'b1;
                    data_byte <= next_req.data;
                    final_byte <= next_req.fin;
                end
                else
                begin
                    byte_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each accepted unit against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (units_due.size() == 0)
                begin
                    $display("%0t ns: result 0x%0h arrived with no request outstanding",
                             $time, code_unit);
                    mismatch_count++;
                end
                else
                begin
                    due = units_due.pop_front();
                    if (due.valid)
                        check_field("code_unit", due.code, code_unit);
                    check_field("unit_valid", 16'(due.valid), 16'(unit_valid));
                    check_field("run_last", 16'(due.last), 16'(run_last));
                    check_field("string_end", 16'(due.str_end), 16'(string_end));
                end
            end
            result_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] opening [19];
        int         target;
        int         phase;
        int         k;

        // Character extremes, overlong forms, stray leads and the largest code point.
        opening = '{8'h00, 8'h7F, 8'hC0, 8'h80, 8'hDF, 8'hBF, 8'h80, 8'hFF,
                    8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h90, 8'h80, 8'h80,
                    8'hF7, 8'hBF, 8'hBF, 8'hBF};
        for (k = 0; k < 19; k++)
            push_byte(opening[k], k == 18);
        // Four-byte lead cut short: the held bytes decode again as a new character.
        push_byte(8'hF4, 1'b0);
        push_byte(8'hC2, 1'b0);
        push_byte(8'hA9, 1'b1);
        // A multi-byte lead as the last byte, then a stray last byte.
        push_byte(8'hC3, 1'b1);
        push_byte(8'h80, 1'b1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 65 : 0;
            recv_stall_pct = (phase == 0) ? 65 : (phase == 1) ? 28 : 0;
            target = queued_total + BYTES_PER_PHASE;
            while (queued_total < target)
                random_string();
            while (bytes_to_send.size() != 0)
                @(posedge clk);
        end

        while (bytes_to_send.size() != 0 || byte_valid || units_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && units_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
